[hdl/comb_allpass_reverb_unit_assert.svh]
// Assertion macros for the reverb unit
`ifndef COMB_ALLPASS_REVERB_UNIT_ASSERT_SVH
`define COMB_ALLPASS_REVERB_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CRU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define CRU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define CRU_ASSERT_IMP(lbl, ante, cons)
`define CRU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hdl/cru_pkg.sv]
// Package: constants, types and arithmetic helpers for the reverb unit
`timescale 1ns / 1ps
`default_nettype none
package cru_pkg;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COMB_DEPTH   = 2048;
    localparam int AP_DEPTH     = 1024;
    localparam int NUM_COMBS    = 8;
    localparam int NUM_AP       = 4;
    localparam int CAW  = $clog2(COMB_DEPTH);
    localparam int AAW  = $clog2(AP_DEPTH);
    localparam int CNTW = $clog2(COMB_DEPTH + 1);
    localparam int PW   = CNTW + 1;
    localparam int KW   = $clog2(NUM_COMBS);
    localparam int JW   = $clog2(NUM_AP);
    localparam int GW   = 15;
    localparam int IDXW = 3;

    localparam logic [IDXW-1:0] REG_FEEDBACK = 3'd0;
    localparam logic [IDXW-1:0] REG_DAMPING  = 3'd1;
    localparam logic [IDXW-1:0] REG_APGAIN   = 3'd2;
    localparam logic [IDXW-1:0] REG_WET      = 3'd3;
    localparam logic [IDXW-1:0] REG_DRY      = 3'd4;

    localparam logic [CNTW-1:0] COMB_DELAY [NUM_COMBS] = '{
        CNTW'(1556), CNTW'(1616), CNTW'(1490), CNTW'(1421),
        CNTW'(1276), CNTW'(1355), CNTW'(1187), CNTW'(1115)};
    localparam logic [CNTW-1:0] AP_DELAY [NUM_AP] = '{
        CNTW'(224), CNTW'(555), CNTW'(440), CNTW'(340)};

    typedef logic signed [SAMPLE_WIDTH-1:0] t_smp;
    typedef logic signed [23:0] t_d24;

    typedef struct packed {
        logic [GW-1:0] feedback;
        logic [GW-1:0] damping;
        logic [GW-1:0] ap_gain;
        logic [GW-1:0] wet;
        logic [GW-1:0] dry;
    } t_cfg;

    typedef struct packed {
        logic pop;
        logic busy;
    } t_bstat;

    // product / 32768, truncated toward zero
    function automatic logic signed [25:0] qtr(input logic signed [40:0] p);
        logic signed [40:0] m;
        m = -p;
        if (p < 0) return -$signed(m[40:15]);
        return $signed(p[40:15]);
    endfunction

    function automatic t_d24 sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607)  return 24'sh7FFFFF;
        if (v < -27'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic t_smp sat_smp(input logic signed [26:0] v);
        logic signed [26:0] hi;
        logic signed [26:0] lo;
        hi = 27'((28'sd1 <<< (SAMPLE_WIDTH - 1)) - 28'sd1);
        lo = -hi - 27'sd1;
        if (v > hi) return hi[SAMPLE_WIDTH-1:0];
        if (v < lo) return lo[SAMPLE_WIDTH-1:0];
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    // value / 8, truncated toward zero
    function automatic logic signed [20:0] div8(input t_d24 y);
        logic signed [23:0] m;
        m = -y;
        if (y < 0) return -$signed(m[23:3]);
        return $signed(y[23:3]);
    endfunction
endpackage
`default_nettype wire

[hdl/comb_allpass_reverb_unit.sv]
// Top level: eight damped combs into four allpass stages, dry/wet mix
// Usage:
//  Input channel: i_valid / o_stall with i_sample_in; a transaction moves
//  one signed sample. Output channel: o_valid / i_stall with o_sample_out,
//  one mixed sample per input transaction, in order.
//  A two-entry input queue takes samples while the filter core works and
//  while a finished result waits in the output register.
//  The core works on one sample at a time, paced by the single shared
//  multiplier and the one read/one write port of each delay memory:
//  states C0 to C3 per comb, A0 to A2 per allpass, O0 to O2 for the final
//  mix, and IDLE, where it dequeues only once the result register is empty.
//  Reset: gains return to their defaults, lowpass state and positions
//  clear; delay lines read as zero until written, tracked by a fill count,
//  so there is no clearing pass and samples are taken right after reset.
//  When the receiver stalls, the result holds, the core takes no new sample
//  until the result is taken, and o_stall rises once the queue is full.
//  Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) apply at once.
`timescale 1ns / 1ps
`default_nettype none
`include "comb_allpass_reverb_unit_assert.svh"
module comb_allpass_reverb_unit
    import cru_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire t_smp            i_sample_in,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output t_smp                 o_sample_out,
    input  wire logic            i_cfg_we,
    input  wire logic [IDXW-1:0] i_cfg_idx,
    input  wire logic [GW-1:0]   i_cfg_data
);
    t_cfg   r_cfg;
    t_bstat bstat;
    logic   q_valid;
    t_smp   q_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feedback <= 15'd24576;
            r_cfg.damping  <= 15'd6554;
            r_cfg.ap_gain  <= 15'd16384;
            r_cfg.wet      <= 15'd6554;
            r_cfg.dry      <= 15'd26214;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FEEDBACK: r_cfg.feedback <= i_cfg_data;
                REG_DAMPING:  r_cfg.damping  <= i_cfg_data;
                REG_APGAIN:   r_cfg.ap_gain  <= i_cfg_data;
                REG_WET:      r_cfg.wet      <= i_cfg_data;
                REG_DRY:      r_cfg.dry      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cru_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_sample   (i_sample_in),
        .i_pop      (bstat.pop),
        .o_q_valid  (q_valid),
        .o_q_sample (q_sample)
    );

    cru_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_sample (q_sample),
        .o_stat     (bstat),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_sample   (o_sample_out)
    );

    `CRU_ASSERT_IMP(a_pop_needs_item, bstat.pop, q_valid)
    `CRU_ASSERT_NXT(a_pop_starts_core, bstat.pop, bstat.busy)
    `CRU_ASSERT_IMP(a_result_from_core, $rose(o_valid), $past(bstat.busy))
endmodule
`default_nettype wire

[hdl/cru_front.sv]
// Front end: accepts input samples into a two-entry queue
`timescale 1ns / 1ps
`default_nettype none
module cru_front
    import cru_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_smp i_sample,
    input  wire logic i_pop,
    output logic      o_q_valid,
    output t_smp      o_q_sample
);
    t_smp       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_stall    = (r_cnt == 2'd2);
    assign push       = i_valid && !o_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_sample = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_sample;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

[hdl/cru_back.sv]
// Back end: comb and allpass sequencer on one multiplier and two delay memories
`timescale 1ns / 1ps
`default_nettype none
module cru_back
    import cru_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_valid,
    input  wire t_smp i_q_sample,
    output t_bstat    o_stat,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_smp      o_sample
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_C0   = 4'd1;
    localparam logic [3:0] S_C1   = 4'd2;
    localparam logic [3:0] S_C2   = 4'd3;
    localparam logic [3:0] S_C3   = 4'd4;
    localparam logic [3:0] S_A0   = 4'd5;
    localparam logic [3:0] S_A1   = 4'd6;
    localparam logic [3:0] S_A2   = 4'd7;
    localparam logic [3:0] S_O0   = 4'd8;
    localparam logic [3:0] S_O1   = 4'd9;
    localparam logic [3:0] S_O2   = 4'd10;

    logic [23:0] r_cmem [NUM_COMBS * (2 ** CAW)];
    logic [23:0] r_amem [NUM_AP * (2 ** AAW)];

    logic [3:0]          r_st, n_st;
    logic [KW-1:0]       r_k;
    t_smp                r_x;
    t_d24                r_lp [NUM_COMBS];
    t_d24                r_y;
    t_d24                r_v;
    t_d24                r_s;
    logic signed [25:0]  r_t;
    logic signed [26:0]  r_sum;
    logic signed [40:0]  r_prod;
    logic [CAW-1:0]      r_cpos;
    logic [AAW-1:0]      r_apos;
    logic [CNTW-1:0]     r_cnt;
    logic                r_cok;
    logic                r_aok;
    logic [23:0]         r_crd;
    logic [23:0]         r_ard;
    logic                r_ovalid;
    t_smp                r_osmp;

    logic [15:0]         mul_a;
    t_d24                mul_b;
    t_d24                x_ext;
    t_d24                y_now;
    t_d24                v_now;
    logic [JW-1:0]       j;
    logic [PW-1:0]       c_rd;
    logic [PW-1:0]       a_rd;
    logic                cwe;
    logic                awe;
    logic                pop;

    assign x_ext = 24'(r_x);
    assign j     = r_k[JW-1:0];
    assign y_now = r_cok ? $signed(r_crd) : '0;
    assign v_now = r_aok ? $signed(r_ard) : '0;
    assign pop   = (r_st == S_IDLE) && i_q_valid && !r_ovalid;
    assign cwe   = (r_st == S_C1);
    assign awe   = (r_st == S_A2);

    // read positions behind the write position, wrapping at the ring depth
    always_comb begin
        if (PW'(r_cpos) >= PW'(COMB_DELAY[r_k]))
            c_rd = PW'(r_cpos) - PW'(COMB_DELAY[r_k]);
        else
            c_rd = PW'(r_cpos) + PW'(COMB_DEPTH) - PW'(COMB_DELAY[r_k]);
        if (PW'(r_apos) >= PW'(AP_DELAY[j]))
            a_rd = PW'(r_apos) - PW'(AP_DELAY[j]);
        else
            a_rd = PW'(r_apos) + PW'(AP_DEPTH) - PW'(AP_DELAY[j]);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        n_st  = r_st;
        unique case (r_st)
            S_IDLE: if (pop) n_st = S_C0;
            S_C0: begin
                mul_a = 16'(i_cfg.feedback);
                mul_b = r_lp[r_k];
                n_st  = S_C1;
            end
            S_C1: begin
                mul_a = 16'd32768 - 16'(i_cfg.damping);
                mul_b = y_now;
                n_st  = S_C2;
            end
            S_C2: begin
                mul_a = 16'(i_cfg.damping);
                mul_b = r_lp[r_k];
                n_st  = S_C3;
            end
            S_C3: n_st = (r_k == KW'(NUM_COMBS - 1)) ? S_A0 : S_C0;
            S_A0: n_st = S_A1;
            S_A1: begin
                mul_a = 16'(i_cfg.ap_gain);
                mul_b = v_now;
                n_st  = S_A2;
            end
            S_A2: n_st = (j == JW'(NUM_AP - 1)) ? S_O0 : S_A0;
            S_O0: begin
                mul_a = 16'(i_cfg.dry);
                mul_b = x_ext;
                n_st  = S_O1;
            end
            S_O1: begin
                mul_a = 16'(i_cfg.wet);
                mul_b = r_s;
                n_st  = S_O2;
            end
            S_O2: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // delay memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (cwe)
            r_cmem[{r_k, r_cpos}] <= sat24(27'(x_ext) + 27'(qtr(r_prod)));
        r_crd <= r_cmem[{r_k, c_rd[CAW-1:0]}];
        if (awe)
            r_amem[{j, r_apos}] <= sat24(27'(r_s) + 27'(qtr(r_prod)));
        r_ard <= r_amem[{j, a_rd[AAW-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, mul_a}) * mul_b;
        r_cok  <= (r_cnt >= COMB_DELAY[r_k]);
        r_aok  <= (r_cnt >= AP_DELAY[j]);
        if (pop) r_x <= i_q_sample;
        case (r_st)
            S_C1: r_y <= y_now;
            S_C2: r_t <= qtr(r_prod);
            S_C3: r_s <= sat24(r_sum + 27'(div8(r_y)));
            S_A1: r_v <= v_now;
            S_A2: r_s <= sat24(27'(r_v) - 27'(r_s));
            S_O1: r_t <= qtr(r_prod);
            S_O2: r_osmp <= sat_smp(27'(r_t) + 27'(qtr(r_prod)));
            default: ;
        endcase
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_k      <= '0;
            r_sum    <= '0;
            r_cpos   <= '0;
            r_apos   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_COMBS; i++) r_lp[i] <= '0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (pop) begin
                    r_k   <= '0;
                    r_sum <= '0;
                end
                S_C3: begin
                    r_lp[r_k] <= sat24(27'(r_t) + 27'(qtr(r_prod)));
                    r_sum     <= r_sum + 27'(div8(r_y));
                    r_k       <= (r_k == KW'(NUM_COMBS - 1)) ? '0 : r_k + 1'b1;
                end
                S_A2: r_k <= (j == JW'(NUM_AP - 1)) ? '0 : r_k + 1'b1;
                S_O2: begin
                    r_ovalid <= 1'b1;
                    r_cpos <= (r_cpos == CAW'(COMB_DEPTH - 1)) ? '0 : r_cpos + 1'b1;
                    r_apos <= (r_apos == AAW'(AP_DEPTH - 1)) ? '0 : r_apos + 1'b1;
                    if (r_cnt != CNTW'(COMB_DEPTH)) r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.pop  = pop;
    assign o_stat.busy = (r_st != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_sample    = r_osmp;
endmodule
`default_nettype wire

[verif/reverb_checker.sv]
// Checker: watches both channels, predicts the reverb output and compares
`timescale 1ns / 1ps
module reverb_checker
    import cru_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall_in,
    input  t_smp            i_sample_in,
    input  logic            i_out_valid,
    input  logic            i_stall_out,
    input  t_smp            i_sample_out,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_idx,
    input  logic [GW-1:0]   i_cfg_data,
    output int              o_errors,
    output int              o_pending
);
    localparam int CDLY [NUM_COMBS] = '{1556, 1616, 1490, 1421, 1276, 1355, 1187, 1115};
    localparam int ADLY [NUM_AP] = '{224, 555, 440, 340};

    longint comb_ring [NUM_COMBS][COMB_DEPTH];
    longint damp_state [NUM_COMBS];
    longint ap_ring [NUM_AP][AP_DEPTH];
    int     comb_wr;
    int     ap_wr;
    longint g_fb, g_damp, g_ap, g_wet, g_dry;
    t_smp   expected_samples [$];

    function automatic longint scale_q15(longint gain, longint v);
        longint p;
        p = gain * v;
        if (p < 0) return -((-p) >>> 15);
        return p >>> 15;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint clip24(longint v);
        return clip(v, -8388608, 8388607);
    endfunction

    function automatic t_smp reverb_sample(t_smp xin);
        longint x, y, acc, s, v, mix;
        int rd;
        x = longint'(xin);
        acc = 0;
        for (int k = 0; k < NUM_COMBS; k++) begin
            rd = (comb_wr + COMB_DEPTH - CDLY[k]) % COMB_DEPTH;
            comb_ring[k][comb_wr] = clip24(x + scale_q15(g_fb, damp_state[k]));
            y = comb_ring[k][rd];
            damp_state[k] = clip24(scale_q15(32768 - g_damp, y)
                                   + scale_q15(g_damp, damp_state[k]));
            acc += (y < 0) ? -((-y) >>> 3) : (y >>> 3);
        end
        s = clip24(acc);
        for (int j = 0; j < NUM_AP; j++) begin
            rd = (ap_wr + AP_DEPTH - ADLY[j]) % AP_DEPTH;
            v = ap_ring[j][rd];
            ap_ring[j][ap_wr] = clip24(s + scale_q15(g_ap, v));
            s = clip24(v - s);
        end
        mix = clip(scale_q15(g_dry, x) + scale_q15(g_wet, s), -32768, 32767);
        comb_wr = (comb_wr + 1) % COMB_DEPTH;
        ap_wr = (ap_wr + 1) % AP_DEPTH;
        return t_smp'(mix);
    endfunction

    assign o_pending = expected_samples.size();

    always @(posedge i_clk) begin
        t_smp want;
        if (!i_rst_n) begin
            foreach (comb_ring[k, n]) comb_ring[k][n] = 0;
            foreach (ap_ring[j, n]) ap_ring[j][n] = 0;
            foreach (damp_state[k]) damp_state[k] = 0;
            comb_wr = 0;
            ap_wr = 0;
            g_fb = 24576; g_damp = 6554; g_ap = 16384; g_wet = 6554; g_dry = 26214;
            expected_samples.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FEEDBACK: g_fb = i_cfg_data;
                    REG_DAMPING:  g_damp = i_cfg_data;
                    REG_APGAIN:   g_ap = i_cfg_data;
                    REG_WET:      g_wet = i_cfg_data;
                    REG_DRY:      g_dry = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                expected_samples.push_back(reverb_sample(i_sample_in));
            if (i_out_valid && !i_stall_out) begin
                if (expected_samples.size() == 0) begin
                    if (o_errors < 10) $display("unexpected transaction: %0d", i_sample_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_samples.pop_front();
                    if (want !== i_sample_out) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %0d actual %0d", want, i_sample_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/testbench.sv]
// Testbench top: drives samples and register writes, gives the verdict
`timescale 1ns / 1ps
module testbench;
    import cru_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            i_valid = 0;
    logic            o_stall;
    t_smp            i_sample_in = '0;
    logic            o_valid;
    logic            i_stall = 0;
    t_smp            o_sample_out;
    logic            i_cfg_we = 0;
    logic [IDXW-1:0] i_cfg_idx = '0;
    logic [GW-1:0]   i_cfg_data = '0;
    int              errors;
    int              pending;
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    int              hold_off = 0;
    int              idle_cycles = 0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    comb_allpass_reverb_unit u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_sample_in, .o_valid, .i_stall,
        .o_sample_out, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    reverb_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_sample_in,
        .i_out_valid(o_valid), .i_stall_out(i_stall), .i_sample_out(o_sample_out),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays high into the next transaction; drain() drops it
    task automatic send_sample(input t_smp s);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_in <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [GW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // audio-like values half the time, otherwise random or full scale
    function automatic t_smp rand_sample();
        case ($urandom_range(3))
            0: return t_smp'($urandom);
            1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return t_smp'($signed($urandom_range(8000)) - 4000);
        endcase
    endfunction

    initial begin
        t_smp directed [10] = '{16'sh7FFF, 16'sh8000, 0, 1, -1, 16'sh7FFF, 16'sh7FFF,
                               16'sh8000, 16'sh5555, 16'shAAAA};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[n]) send_sample(directed[n]);
        drain();
        write_reg(REG_FEEDBACK, 15'h7FFF);
        write_reg(REG_DAMPING, 15'd0);
        write_reg(REG_APGAIN, 15'h7FFF);
        write_reg(REG_WET, 15'h7FFF);
        write_reg(REG_DRY, 15'h7FFF);
        write_reg(3'd7, 15'd0); // unmapped index, ignored
        repeat (10) send_sample($urandom_range(1) ? 16'sh7FFF : 16'sh8000);
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 76; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 76; end
                3: begin send_idle_pct = 24; stall_pct = 24; end
                default: begin send_idle_pct = $urandom_range(1) * 30; stall_pct = 10; end
            endcase
            write_reg(REG_FEEDBACK, phase == 5 ? 15'd0 : GW'($urandom));
            write_reg(REG_DAMPING, phase == 4 ? 15'h7FFF : GW'($urandom));
            write_reg(REG_APGAIN, phase == 5 ? 15'd0 : GW'($urandom));
            write_reg(REG_WET, GW'($urandom));
            write_reg(REG_DRY, phase == 5 ? 15'd0 : GW'($urandom));
            if (phase == 2) hold_off <= 600;
            repeat (300) send_sample(rand_sample());
        end
        drain();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
